>>> hdl/cau_pkg.sv
// ----------------------------------------------------------------------------
// cau_pkg: shared definitions of the complex arithmetic unit
// Formats, operation codes and the command that the front hands to the back.
// ----------------------------------------------------------------------------
package cau_pkg;

	localparam int DW     = 16;             // width of one operand or result part
	localparam int FB     = 8;              // fraction bits
	localparam int PW     = 2 * DW;         // width of a full product
	localparam int SW     = PW + 1;         // width of a sum of two products
	localparam int QW     = DW;             // quotient bits produced by the divider
	localparam int RW     = PW + QW;        // divider remainder width
	localparam int QDEPTH = 4;              // entries of the command queue
	localparam int QAW    = $clog2(QDEPTH);

	typedef enum logic [1:0] {
		OP_ADD = 2'd0,
		OP_SUB = 2'd1,
		OP_MUL = 2'd2,
		OP_DIV = 2'd3
	} op_t;

	typedef struct packed {
		op_t                   op;
		logic                  dz;
		logic signed [DW-1:0]  a_re;
		logic signed [DW-1:0]  a_im;
		logic signed [DW-1:0]  b_re;
		logic signed [DW-1:0]  b_im;
	} cmd_t;

endpackage

>>> hdl/cau_if.sv
// ----------------------------------------------------------------------------
// cau_if: channel interfaces of the complex arithmetic unit
// Operand channel and result channel, each with valid, ready and payload.
// ----------------------------------------------------------------------------
interface cau_req_if;
	logic                         valid;
	logic                         ready;
	logic [1:0]                   mode;
	logic signed [cau_pkg::DW-1:0] a_re;
	logic signed [cau_pkg::DW-1:0] a_im;
	logic signed [cau_pkg::DW-1:0] b_re;
	logic signed [cau_pkg::DW-1:0] b_im;

	modport source (output valid, mode, a_re, a_im, b_re, b_im, input ready);
	modport sink (input valid, mode, a_re, a_im, b_re, b_im, output ready);
endinterface

interface cau_rsp_if;
	logic                         valid;
	logic                         ready;
	logic signed [cau_pkg::DW-1:0] res_re;
	logic signed [cau_pkg::DW-1:0] res_im;
	logic                         overflow;
	logic                         div_zero;

	modport source (output valid, res_re, res_im, overflow, div_zero, input ready);
	modport sink (input valid, res_re, res_im, overflow, div_zero, output ready);
endinterface

>>> hdl/cau_front.sv
// ----------------------------------------------------------------------------
// cau_front: operand intake
// Decodes the mode and flags a zero divisor before the item is queued.
// ----------------------------------------------------------------------------
module cau_front (
	cau_req_if.sink       req,
	input  logic          q_ready,
	output logic          q_valid,
	output cau_pkg::cmd_t q_cmd
);
	import cau_pkg::*;

	op_t op;

	assign op        = op_t'(req.mode);
	assign req.ready = q_ready;
	assign q_valid   = req.valid;

	always_comb begin
		q_cmd.op   = op;
		q_cmd.dz   = (op == OP_DIV) && (req.b_re == '0) && (req.b_im == '0);
		q_cmd.a_re = req.a_re;
		q_cmd.a_im = req.a_im;
		q_cmd.b_re = req.b_re;
		q_cmd.b_im = req.b_im;
	end

endmodule

>>> hdl/cau_queue.sv
// ----------------------------------------------------------------------------
// cau_queue: command queue
// Small FIFO that lets the front keep accepting while the back is stalled.
// ----------------------------------------------------------------------------
module cau_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr_valid,
	output logic          wr_ready,
	input  cau_pkg::cmd_t wr_data,
	output logic          rd_valid,
	input  logic          rd_ready,
	output cau_pkg::cmd_t rd_data
);
	import cau_pkg::*;

	cmd_t           mem_q [QDEPTH];
	logic [QAW-1:0] wr_ptr_q;
	logic [QAW-1:0] rd_ptr_q;
	logic [QAW:0]   count_q;
	logic           push;
	logic           pop;

	assign wr_ready = (count_q != (QAW+1)'(QDEPTH));
	assign rd_valid = (count_q != '0);
	assign rd_data  = mem_q[rd_ptr_q];
	assign push     = wr_valid && wr_ready;
	assign pop      = rd_valid && rd_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop) rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop) count_q <= count_q + 1'b1;
			else if (pop && !push) count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= wr_data;
	end

endmodule

>>> hdl/cau_back.sv
// ----------------------------------------------------------------------------
// cau_back: arithmetic pipeline
// Products, sums, sign split, a one-bit-per-stage divider and saturation.
// ----------------------------------------------------------------------------
module cau_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  cau_pkg::cmd_t in_cmd,
	cau_rsp_if.source     rsp
);
	import cau_pkg::*;

	typedef struct packed {
		op_t             op;
		logic            dz;
		logic            neg_re;
		logic            neg_im;
		logic            big_re;
		logic            big_im;
		logic [SW-1:0]   mag_re;
		logic [SW-1:0]   mag_im;
		logic [RW-1:0]   rem_re;
		logic [RW-1:0]   rem_im;
		logic [QW-1:0]   q_re;
		logic [QW-1:0]   q_im;
		logic [PW-1:0]   den;
	} dstage_t;

	function automatic logic [DW:0] sat(input logic neg, input logic [SW-1:0] mag);
		logic [SW-1:0] lim;
		logic [DW-1:0] v;
		logic          ov;
		lim = SW'(1) << (DW - 1);
		if (!neg) begin
			if (mag > lim - 1'b1) begin
				ov = 1'b1;
				v  = DW'(lim - 1'b1);
			end else begin
				ov = 1'b0;
				v  = DW'(mag);
			end
		end else if (mag > lim) begin
			ov = 1'b1;
			v  = DW'(lim);
		end else begin
			ov = 1'b0;
			v  = DW'(-mag);
		end
		return {ov, v};
	endfunction

	logic en;

	// stage 1
	logic                 v_s1;
	op_t                  op_s1;
	logic                 dz_s1;
	logic signed [PW-1:0] p_rr_s1, p_ii_s1, p_ri_s1, p_ir_s1, sq_r_s1, sq_i_s1;
	logic signed [DW:0]   as_re_s1, as_im_s1;
	logic signed [DW:0]   as_re, as_im;

	// stage 2
	logic                 v_s2;
	op_t                  op_s2;
	logic                 dz_s2;
	logic signed [SW-1:0] s_re_s2, s_im_s2;
	logic [PW-1:0]        den_s2;
	logic signed [SW-1:0] s_re, s_im;

	// stage 3 and divider stages
	logic                 dv_v_s3 [QW+1];
	dstage_t              dv_s3 [QW+1];
	dstage_t              st3;
	logic [SW-1:0]        m_re, m_im;

	// output
	logic                 out_v_q;
	logic signed [DW-1:0] out_re_q, out_im_q;
	logic                 out_ov_q, out_dz_q;
	dstage_t              last;
	logic [SW-1:0]        fm_re, fm_im;
	logic [DW:0]          f_re, f_im;

	assign en       = !out_v_q || rsp.ready;
	assign in_ready = en;

	always_comb begin
		if (in_cmd.op == OP_SUB) begin
			as_re = $signed({in_cmd.a_re[DW-1], in_cmd.a_re}) -
				$signed({in_cmd.b_re[DW-1], in_cmd.b_re});
			as_im = $signed({in_cmd.a_im[DW-1], in_cmd.a_im}) -
				$signed({in_cmd.b_im[DW-1], in_cmd.b_im});
		end else begin
			as_re = $signed({in_cmd.a_re[DW-1], in_cmd.a_re}) +
				$signed({in_cmd.b_re[DW-1], in_cmd.b_re});
			as_im = $signed({in_cmd.a_im[DW-1], in_cmd.a_im}) +
				$signed({in_cmd.b_im[DW-1], in_cmd.b_im});
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			op_s1    <= in_cmd.op;
			dz_s1    <= in_cmd.dz;
			p_rr_s1  <= $signed(in_cmd.a_re) * $signed(in_cmd.b_re);
			p_ii_s1  <= $signed(in_cmd.a_im) * $signed(in_cmd.b_im);
			p_ri_s1  <= $signed(in_cmd.a_re) * $signed(in_cmd.b_im);
			p_ir_s1  <= $signed(in_cmd.a_im) * $signed(in_cmd.b_re);
			sq_r_s1  <= $signed(in_cmd.b_re) * $signed(in_cmd.b_re);
			sq_i_s1  <= $signed(in_cmd.b_im) * $signed(in_cmd.b_im);
			as_re_s1 <= as_re;
			as_im_s1 <= as_im;
		end
	end

	always_comb begin
		case (op_s1)
			OP_MUL: begin
				s_re = SW'(p_rr_s1) - SW'(p_ii_s1);
				s_im = SW'(p_ri_s1) + SW'(p_ir_s1);
			end
			OP_DIV: begin
				s_re = SW'(p_rr_s1) + SW'(p_ii_s1);
				s_im = SW'(p_ir_s1) - SW'(p_ri_s1);
			end
			default: begin
				s_re = SW'(as_re_s1);
				s_im = SW'(as_im_s1);
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) begin
			op_s2   <= op_s1;
			dz_s2   <= dz_s1;
			s_re_s2 <= s_re;
			s_im_s2 <= s_im;
			den_s2  <= $unsigned(sq_r_s1) + $unsigned(sq_i_s1);
		end
	end

	// Split into sign and magnitude; a product is scaled back here, which
	// truncates toward zero.
	always_comb begin
		m_re = s_re_s2[SW-1] ? SW'(-s_re_s2) : SW'(s_re_s2);
		m_im = s_im_s2[SW-1] ? SW'(-s_im_s2) : SW'(s_im_s2);
		if (op_s2 == OP_MUL) begin
			m_re = m_re >> FB;
			m_im = m_im >> FB;
		end
		st3.op     = op_s2;
		st3.dz     = dz_s2;
		st3.neg_re = s_re_s2[SW-1];
		st3.neg_im = s_im_s2[SW-1];
		st3.mag_re = m_re;
		st3.mag_im = m_im;
		st3.rem_re = RW'(m_re) << FB;
		st3.rem_im = RW'(m_im) << FB;
		st3.big_re = (RW'(m_re) << FB) >= (RW'(den_s2) << QW);
		st3.big_im = (RW'(m_im) << FB) >= (RW'(den_s2) << QW);
		st3.q_re   = '0;
		st3.q_im   = '0;
		st3.den    = den_s2;
	end

	always_ff @(posedge clk) begin
		if (en) dv_s3[0] <= st3;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1       <= 1'b0;
			v_s2       <= 1'b0;
			dv_v_s3[0] <= 1'b0;
		end else if (en) begin
			v_s1       <= in_valid;
			v_s2       <= v_s1;
			dv_v_s3[0] <= v_s2;
		end
	end

	// Restoring divider, one quotient bit per stage, most significant first.
	for (genvar j = 0; j < QW; j++) begin : g_div
		localparam int K = QW - 1 - j;
		logic [RW-1:0] trial;
		dstage_t       nxt;

		always_comb begin
			nxt   = dv_s3[j];
			trial = RW'(dv_s3[j].den) << K;
			if (nxt.rem_re >= trial) begin
				nxt.rem_re  = nxt.rem_re - trial;
				nxt.q_re[K] = 1'b1;
			end
			if (nxt.rem_im >= trial) begin
				nxt.rem_im  = nxt.rem_im - trial;
				nxt.q_im[K] = 1'b1;
			end
		end

		always_ff @(posedge clk) begin
			if (en) dv_s3[j+1] <= nxt;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) dv_v_s3[j+1] <= 1'b0;
			else if (en) dv_v_s3[j+1] <= dv_v_s3[j];
		end
	end

	always_comb begin
		last = dv_s3[QW];
		if (last.op == OP_DIV) begin
			fm_re = last.big_re ? '1 : SW'(last.q_re);
			fm_im = last.big_im ? '1 : SW'(last.q_im);
		end else begin
			fm_re = last.mag_re;
			fm_im = last.mag_im;
		end
		if (last.dz) begin
			fm_re = '0;
			fm_im = '0;
		end
		f_re = sat(last.neg_re, fm_re);
		f_im = sat(last.neg_im, fm_im);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_v_q <= 1'b0;
		else if (en) out_v_q <= dv_v_s3[QW];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_re_q <= f_re[DW-1:0];
			out_im_q <= f_im[DW-1:0];
			out_ov_q <= f_re[DW] || f_im[DW];
			out_dz_q <= last.dz;
		end
	end

	assign rsp.valid    = out_v_q;
	assign rsp.res_re   = out_re_q;
	assign rsp.res_im   = out_im_q;
	assign rsp.overflow = out_ov_q;
	assign rsp.div_zero = out_dz_q;

endmodule

>>> hdl/complex_arithmetic_unit.sv
// ----------------------------------------------------------------------------
// complex_arithmetic_unit: complex add, subtract, multiply and divide
// Signed Q8.8 complex ALU with saturation and zero-divisor detection.
// ----------------------------------------------------------------------------
// The req channel carries one item per handshake: a mode (add, subtract,
// multiply, divide) and two complex operands in Q8.8. The rsp channel returns
// exactly one result item per accepted item, in order: the real and imaginary
// parts in Q8.8, an overflow flag when either part saturated, and a
// divide-by-zero flag, in which case both parts are zero.
//
// Throughput is one item per cycle while the receiver keeps up. An accepted
// item is written into the command queue, leaves it into the product stage,
// then passes the sum and sign-split stages, sixteen divider stages that each
// resolve one quotient bit, and the output register. Every mode passes through
// the same stages, so results always leave in order.
//
// When the receiver stalls, the output register holds its item and the whole
// arithmetic pipeline freezes; the four-entry command queue keeps accepting
// until it fills, and only then req.ready falls. Reset empties the queue and
// clears every pipeline valid bit; no result is shown until a new item passes.
module complex_arithmetic_unit (
	input  logic      clk,
	input  logic      arst_n,
	cau_req_if.sink   req,
	cau_rsp_if.source rsp
);
	import cau_pkg::*;

	logic f_valid;
	logic f_ready;
	cmd_t f_cmd;
	logic b_valid;
	logic b_ready;
	cmd_t b_cmd;

	// Front: decodes the mode and flags a zero divisor.
	cau_front u_front (
		.req     (req),
		.q_ready (f_ready),
		.q_valid (f_valid),
		.q_cmd   (f_cmd)
	);

	// Queue: decouples intake from a stalled back end.
	cau_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (f_valid),
		.wr_ready (f_ready),
		.wr_data  (f_cmd),
		.rd_valid (b_valid),
		.rd_ready (b_ready),
		.rd_data  (b_cmd)
	);

	// Back: the arithmetic pipeline and output register.
	cau_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (b_valid),
		.in_ready (b_ready),
		.in_cmd   (b_cmd),
		.rsp      (rsp)
	);

endmodule

>>> hdl/cau_checker.sv
// ----------------------------------------------------------------------------
// cau_checker: port-level assertions of the complex arithmetic unit
// Checks reset behavior, result holding and the flag rules on the rsp port.
// ----------------------------------------------------------------------------
module cau_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        rsp_valid,
	input logic                        rsp_ready,
	input logic signed [cau_pkg::DW-1:0] res_re,
	input logic signed [cau_pkg::DW-1:0] res_im,
	input logic                        overflow,
	input logic                        div_zero
);
	import cau_pkg::*;

	localparam logic [DW-1:0] MAX_P = {1'b0, {(DW-1){1'b1}}};
	localparam logic [DW-1:0] MIN_N = {1'b1, {(DW-1){1'b0}}};

	a_reset_quiet: assert property (@(posedge clk) !arst_n |-> !rsp_valid)
		else $error("result shown during reset");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(res_re) && $stable(res_im)
			&& $stable(overflow) && $stable(div_zero))
		else $error("stalled result changed");

	a_div_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && div_zero |-> res_re == '0 && res_im == '0 && !overflow)
		else $error("zero divisor result not cleared");

	a_sat: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && overflow |-> res_re == MAX_P || res_re == MIN_N
			|| res_im == MAX_P || res_im == MIN_N)
		else $error("overflow without a saturated part");

endmodule

bind complex_arithmetic_unit cau_checker u_cau_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.rsp_valid (rsp.valid),
	.rsp_ready (rsp.ready),
	.res_re    (rsp.res_re),
	.res_im    (rsp.res_im),
	.overflow  (rsp.overflow),
	.div_zero  (rsp.div_zero)
);

>>> verif/cau_checker.sv
// ----------------------------------------------------------------------------
// cau_scoreboard: result prediction and comparison for the complex arithmetic unit
// Watches both channels, computes the expected complex result of every
// accepted item and compares each returned item field by field, in order.
// ----------------------------------------------------------------------------
module cau_scoreboard (
	input  logic      clk,
	input  logic      arst_n,
	cau_req_if.sink   req,
	cau_rsp_if.sink   rsp,
	output int        fail_count,
	output int        pending,
	output int        rsp_count,
	output int        ovf_count,
	output int        dz_count
);
	import cau_pkg::*;

	typedef struct {
		logic signed [DW-1:0] re;
		logic signed [DW-1:0] im;
		logic                 ovf;
		logic                 dz;
	} cplx_res_t;

	cplx_res_t result_fifo[$];

	localparam longint POS_MAX = (64'sd1 <<< (DW - 1)) - 1;
	localparam longint NEG_MIN = -(64'sd1 <<< (DW - 1));

	// Clip to the part width, setting the overflow flag when the value is out of range.
	function automatic logic signed [DW-1:0] clip(input longint v, inout logic ovf);
		if (v > POS_MAX) begin
			ovf = 1'b1;
			return POS_MAX[DW-1:0];
		end
		if (v < NEG_MIN) begin
			ovf = 1'b1;
			return NEG_MIN[DW-1:0];
		end
		return v[DW-1:0];
	endfunction

	function automatic longint shr_tz(input longint v);
		if (v < 0)
			return -((-v) >>> FB);
		return v >>> FB;
	endfunction

	// Quotient magnitude truncated, then signed like the numerator.
	function automatic longint div_tz(input longint num, input longint den);
		longint mag;
		longint q;
		mag = (num < 0) ? -num : num;
		q = (mag <<< FB) / den;
		return (num < 0) ? -q : q;
	endfunction

	function automatic cplx_res_t complex_result(input logic [1:0] mode,
			input longint ar, input longint ai, input longint br, input longint bi);
		cplx_res_t r;
		longint re, im, den;
		r.ovf = 1'b0;
		r.dz = 1'b0;
		re = 0;
		im = 0;
		case (op_t'(mode))
			OP_ADD: begin
				re = ar + br;
				im = ai + bi;
			end
			OP_SUB: begin
				re = ar - br;
				im = ai - bi;
			end
			OP_MUL: begin
				re = shr_tz(ar * br - ai * bi);
				im = shr_tz(ar * bi + ai * br);
			end
			default: begin
				den = br * br + bi * bi;
				if (den == 0)
					r.dz = 1'b1;
				else begin
					re = div_tz(ar * br + ai * bi, den);
					im = div_tz(ai * br - ar * bi, den);
				end
			end
		endcase
		r.re = clip(re, r.ovf);
		r.im = clip(im, r.ovf);
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		cplx_res_t want;
		cplx_res_t got;
		logic bad;
		if (!arst_n) begin
			result_fifo.delete();
			fail_count <= 0;
			pending <= 0;
			rsp_count <= 0;
			ovf_count <= 0;
			dz_count <= 0;
		end else begin
			if (req.valid && req.ready)
				result_fifo.push_back(complex_result(req.mode, req.a_re, req.a_im,
						req.b_re, req.b_im));
			if (rsp.valid && rsp.ready) begin
				rsp_count <= rsp_count + 1;
				ovf_count <= ovf_count + rsp.overflow;
				dz_count <= dz_count + rsp.div_zero;
				got = '{rsp.res_re, rsp.res_im, rsp.overflow, rsp.div_zero};
				if (result_fifo.size() == 0) begin
					fail_count <= fail_count + 1;
					if (fail_count < 10)
						$display("unexpected result item re=%0d im=%0d", got.re, got.im);
				end else begin
					want = result_fifo.pop_front();
					bad = (got.re !== want.re) || (got.im !== want.im)
						|| (got.ovf !== want.ovf) || (got.dz !== want.dz);
					if (bad) begin
						fail_count <= fail_count + 1;
						if (fail_count < 10)
							$display({"mismatch: expected re=%0d im=%0d ovf=%b dz=%b,",
								" got re=%0d im=%0d ovf=%b dz=%b"},
								want.re, want.im, want.ovf, want.dz,
								got.re, got.im, got.ovf, got.dz);
					end
				end
			end
			pending <= result_fifo.size();
		end
	end
endmodule

>>> verif/tb_complex_arithmetic_unit.sv
// ----------------------------------------------------------------------------
// tb_complex_arithmetic_unit: stimulus and verdict for the complex ALU
// Drives directed corner items and then random items in all four modes under
// random idling on both channels, and relies on the checker for comparison.
// ----------------------------------------------------------------------------
module tb_complex_arithmetic_unit;
	import cau_pkg::*;

	localparam int N_RANDOM = 1830;
	localparam int LIMIT = 400000;

	logic clk = 1'b0;
	logic arst_n;
	int   cycle = 0;
	int   fail_count, pending, rsp_count, ovf_count, dz_count;

	// Sender and receiver idling may be switched off for the last part of the run.
	bit   calm = 1'b0;
	bit   hold_rsp = 1'b0;
	bit   gap_rsp = 1'b0;

	cau_req_if req ();
	cau_rsp_if rsp ();

	complex_arithmetic_unit i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	cau_scoreboard i_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req),
		.rsp        (rsp),
		.fail_count (fail_count),
		.pending    (pending),
		.rsp_count  (rsp_count),
		.ovf_count  (ovf_count),
		.dz_count   (dz_count)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// The watchdog gives up well past the slowest correct run.
	always @(posedge clk) begin
		cycle <= cycle + 1;
		if (cycle > LIMIT) begin
			$display("[complex_arithmetic_unit] ERROR");
			$finish;
		end
	end

	// Picks an operand part. Half are moderate so that products and quotients
	// land in range, while a share reaches the extremes to exercise saturation.
	function automatic logic [DW-1:0] pick_part();
		case ($urandom_range(0, 9))
			0: return 16'h8000;
			1: return 16'h7fff;
			2: return 16'(0);
			3, 4: return 16'($urandom);
			default: return 16'($signed($urandom_range(0, 4095)) - 2048);
		endcase
	endfunction

	// Offers one item and holds it until the block accepts it. The valid line
	// stays high into the next item when there is no gap, so it is only lowered
	// when a pause actually follows.
	task automatic send_item(input op_t op, input logic [DW-1:0] ar,
			input logic [DW-1:0] ai, input logic [DW-1:0] br, input logic [DW-1:0] bi);
		req.valid <= 1'b1;
		req.mode <= op;
		req.a_re <= ar;
		req.a_im <= ai;
		req.b_re <= br;
		req.b_im <= bi;
		do
			@(posedge clk);
		while (!req.ready);
		if (!calm && $urandom_range(0, 5) == 0) begin
			req.valid <= 1'b0;
			repeat ($urandom_range(1, 13)) @(posedge clk);
		end
	endtask

	task automatic send_random();
		op_t op;
		logic [DW-1:0] br, bi;
		op = op_t'($urandom_range(0, 3));
		br = pick_part();
		bi = pick_part();
		// A zero divisor now and then, so that the divide-by-zero flag is seen.
		if (op == OP_DIV && $urandom_range(0, 19) == 0) begin
			br = '0;
			bi = '0;
		end
		send_item(op, pick_part(), pick_part(), br, bi);
	endtask

	task automatic force_gap(input int n);
		gap_rsp <= 1'b1;
		repeat (n) @(posedge clk);
		gap_rsp <= 1'b0;
	endtask

	// Receiver: random stall bursts, a single long hold-off on request, and
	// steady acceptance once the run is calm.
	always @(posedge clk) begin
		if (!arst_n)
			rsp.ready <= 1'b0;
		else if (hold_rsp || gap_rsp || (!calm && $urandom_range(0, 7) == 0))
			rsp.ready <= 1'b0;
		else
			rsp.ready <= 1'b1;
	end

	initial begin
		// Long receiver hold-off, counted in its own process.
		wait (arst_n);
		repeat (300) @(posedge clk);
		hold_rsp <= 1'b1;
		repeat (120) @(posedge clk);
		hold_rsp <= 1'b0;
	end

	// Random receiver bursts come from a separate process that drops ready for
	// a stretch now and then.
	initial begin
		wait (arst_n);
		while (!calm) begin
			@(posedge clk);
			if ($urandom_range(0, 30) == 0) begin
				force_gap(int'($urandom_range(1, 13)));
			end
		end
	end

	initial begin
		int waited;
		arst_n <= 1'b0;
		req.valid = 1'b0;
		req.mode = '0;
		req.a_re = '0;
		req.a_im = '0;
		req.b_re = '0;
		req.b_im = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed corners: every mode at the extremes, zero divisor, exact
		// division, negative products that truncate toward zero.
		send_item(OP_ADD, 16'h7fff, 16'h8000, 16'h0001, 16'hffff);
		send_item(OP_ADD, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff);
		send_item(OP_ADD, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
		send_item(OP_SUB, 16'h8000, 16'h7fff, 16'h0001, 16'hffff);
		send_item(OP_SUB, 16'h7fff, 16'h8000, 16'h8000, 16'h7fff);
		send_item(OP_SUB, 16'hffff, 16'hffff, 16'hffff, 16'hffff);
		send_item(OP_MUL, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
		send_item(OP_MUL, 16'h7fff, 16'h7fff, 16'h7fff, 16'h8000);
		send_item(OP_MUL, 16'hffff, 16'h0000, 16'h0001, 16'h0000);
		send_item(OP_MUL, 16'h0100, 16'h0000, 16'h0100, 16'h0000);
		send_item(OP_MUL, 16'hff80, 16'h0001, 16'h0003, 16'hff00);
		send_item(OP_DIV, 16'h0100, 16'h0200, 16'h0000, 16'h0000);
		send_item(OP_DIV, 16'h7fff, 16'h8000, 16'h0000, 16'h0000);
		send_item(OP_DIV, 16'h0100, 16'h0000, 16'h0100, 16'h0000);
		send_item(OP_DIV, 16'h7fff, 16'h7fff, 16'h0001, 16'h0000);
		send_item(OP_DIV, 16'h8000, 16'h8000, 16'h0000, 16'h0001);
		send_item(OP_DIV, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
		send_item(OP_DIV, 16'hffff, 16'h0001, 16'h0300, 16'hfd00);
		send_item(OP_DIV, 16'h0001, 16'h0000, 16'h7fff, 16'h7fff);
		send_item(OP_DIV, 16'h5555, 16'haaaa, 16'haaaa, 16'h5555);

		for (int i = 0; i < N_RANDOM; i++) begin
			// Once: the sender waits until every expected result is back.
			if (i == 600) begin
				req.valid <= 1'b0;
				@(posedge clk);
				waited = 0;
				while (pending != 0 && waited < 10000) begin
					@(posedge clk);
					waited++;
				end
			end
			if (i == N_RANDOM - 200)
				calm = 1'b1;
			send_random();
		end
		req.valid <= 1'b0;

		waited = 0;
		while (pending != 0 && waited < 20000) begin
			@(posedge clk);
			waited++;
		end
		repeat (40) @(posedge clk);

		$display("ran %0d items in all four modes; %0d results,", N_RANDOM + 20, rsp_count);
		$display("%0d of them saturated and %0d with a zero divisor", ovf_count, dz_count);
		if (fail_count == 0 && pending == 0)
			$display("[complex_arithmetic_unit] OK");
		else
			$display("[complex_arithmetic_unit] ERROR");
		$finish;
	end
endmodule
